// ----- rtl/core/tsm_pkg.sv -----
package tsm_pkg;

    // Field widths.
    localparam int SPEED_W    = 16;
    localparam int MAX_W      = 15;
    localparam int GAIN_W     = 12;
    localparam int MODE_W     = 3;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Serial multiplier: signed multiplicand times unsigned multiplier.
    localparam int MCAND_W  = 17;
    localparam int MPLIER_W = 12;
    localparam int PROD_W   = MCAND_W + MPLIER_W;
    localparam int CNT_W    = 4;
    localparam int RND_W    = PROD_W - 8;
    localparam int CMD_W    = 22;

    // Q2.8 constants.
    localparam logic signed [10:0] Q_ONE       = 11'sd256;
    localparam logic signed [10:0] RATIO_LIMIT = 11'sd512;

    // Register indexes.
    localparam logic [2:0] REG_MAX_SPEED    = 3'd0;
    localparam logic [2:0] REG_FLIP_LEFT    = 3'd1;
    localparam logic [2:0] REG_FLIP_RIGHT   = 3'd2;
    localparam logic [2:0] REG_CORR_ENABLE  = 3'd3;
    localparam logic [2:0] REG_CORR_GAIN    = 3'd4;

    // Register reset values.
    localparam logic [MAX_W-1:0]  MAX_SPEED_RESET = 15'd2560;
    localparam logic [GAIN_W-1:0] CORR_GAIN_RESET = 12'd128;

    // Command modes.
    typedef enum logic [MODE_W-1:0] {
        MODE_STRAIGHT = 3'd0,
        MODE_ROTATE   = 3'd1,
        MODE_ARC      = 3'd2,
        MODE_STOP     = 3'd3,
        MODE_DIRECT   = 3'd4,
        MODE_TELEM    = 3'd5
    } mode_t;

    typedef struct packed {
        logic [MAX_W-1:0]  max_speed;
        logic              flip_left;
        logic              flip_right;
        logic              correction_enable;
        logic [GAIN_W-1:0] correction_gain;
    } cfg_t;

    typedef struct packed {
        logic                       start;
        logic signed [MCAND_W-1:0]  mcand;
        logic [MPLIER_W-1:0]        mplier;
    } mul_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [PROD_W-1:0]  product;
    } mul_rsp_t;

    // Divide by 256 rounding to nearest, ties toward plus infinity.
    function automatic logic signed [RND_W-1:0] round_q8(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + PROD_W'(128);
        return t[PROD_W-1:8];
    endfunction

    // Saturate a rounded product to the 16 bit signed range.
    function automatic logic signed [SPEED_W-1:0] sat16(input logic signed [RND_W-1:0] v);
        logic signed [SPEED_W-1:0] r;
        if (v > RND_W'(32767)) begin
            r = 16'sh7FFF;
        end else if (v < -RND_W'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[SPEED_W-1:0];
        end
        return r;
    endfunction

    // Clamp a wide signed value to plus or minus the speed limit.
    function automatic logic signed [SPEED_W-1:0] clamp_speed(input logic signed [CMD_W-1:0] v,
                                                               input logic [MAX_W-1:0] lim);
        logic signed [CMD_W-1:0] limw;
        logic signed [CMD_W-1:0] r;
        limw = $signed({{(CMD_W-MAX_W){1'b0}}, lim});
        if (v > limw) begin
            r = limw;
        end else if (v < -limw) begin
            r = -limw;
        end else begin
            r = v;
        end
        return r[SPEED_W-1:0];
    endfunction

endpackage

// ----- rtl/core/tsm_apb_regs.sv -----
module tsm_apb_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tsm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tsm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tsm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output tsm_pkg::cfg_t                    cfg_o
);

    tsm_pkg::cfg_t cfg_reg;
    logic [2:0]    index;
    logic          wr_en;

    assign index  = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg_o  = cfg_reg;

    // Register writes in the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_speed         <= tsm_pkg::MAX_SPEED_RESET;
            cfg_reg.flip_left         <= 1'b0;
            cfg_reg.flip_right        <= 1'b0;
            cfg_reg.correction_enable <= 1'b0;
            cfg_reg.correction_gain   <= tsm_pkg::CORR_GAIN_RESET;
        end else if (wr_en) begin
            unique case (index)
                tsm_pkg::REG_MAX_SPEED:    cfg_reg.max_speed <= pwdata[tsm_pkg::MAX_W-1:0];
                tsm_pkg::REG_FLIP_LEFT:    cfg_reg.flip_left <= pwdata[0];
                tsm_pkg::REG_FLIP_RIGHT:   cfg_reg.flip_right <= pwdata[0];
                tsm_pkg::REG_CORR_ENABLE:  cfg_reg.correction_enable <= pwdata[0];
                tsm_pkg::REG_CORR_GAIN:
                    cfg_reg.correction_gain <= pwdata[tsm_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux.
    always_comb begin
        prdata = '0;
        unique case (index)
            tsm_pkg::REG_MAX_SPEED:
                prdata = {{(tsm_pkg::APB_DATA_W-tsm_pkg::MAX_W){1'b0}}, cfg_reg.max_speed};
            tsm_pkg::REG_FLIP_LEFT:    prdata[0] = cfg_reg.flip_left;
            tsm_pkg::REG_FLIP_RIGHT:   prdata[0] = cfg_reg.flip_right;
            tsm_pkg::REG_CORR_ENABLE:  prdata[0] = cfg_reg.correction_enable;
            tsm_pkg::REG_CORR_GAIN:
                prdata = {{(tsm_pkg::APB_DATA_W-tsm_pkg::GAIN_W){1'b0}},
                          cfg_reg.correction_gain};
            default: prdata = '0;
        endcase
    end

endmodule

// ----- rtl/core/tsm_serial_mul.sv -----
module tsm_serial_mul (
    input  logic                aclk,
    input  logic                aresetn,
    input  tsm_pkg::mul_req_t   req_i,
    output tsm_pkg::mul_rsp_t   rsp_o
);

    logic signed [tsm_pkg::PROD_W-1:0]  p_reg;
    logic signed [tsm_pkg::PROD_W-1:0]  p_next;
    logic signed [tsm_pkg::MCAND_W-1:0] mcand_reg;
    logic [tsm_pkg::CNT_W-1:0]          cnt_reg;
    logic                               busy_reg;
    logic                               done_reg;
    logic signed [tsm_pkg::MCAND_W-1:0] hi;
    logic signed [tsm_pkg::MCAND_W-1:0] addend;
    logic signed [tsm_pkg::MCAND_W:0]   sum;

    // One multiplier bit per cycle: add into the upper half, then shift right.
    always_comb begin
        hi     = p_reg[tsm_pkg::PROD_W-1:tsm_pkg::MPLIER_W];
        addend = p_reg[0] ? mcand_reg : '0;
        sum    = {hi[tsm_pkg::MCAND_W-1], hi} + {addend[tsm_pkg::MCAND_W-1], addend};
        p_next = {sum, p_reg[tsm_pkg::MPLIER_W-1:1]};
    end

    // Control: count the steps and flag the final one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req_i.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == tsm_pkg::CNT_W'(tsm_pkg::MPLIER_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge aclk) begin
        if (req_i.start) begin
            p_reg     <= {{tsm_pkg::MCAND_W{1'b0}}, req_i.mplier};
            mcand_reg <= req_i.mcand;
        end else if (busy_reg) begin
            p_reg <= p_next;
        end
    end

    assign rsp_o.done    = done_reg;
    assign rsp_o.product = p_reg;

    // A new product is never requested while one is being formed.
    assert property (@(posedge aclk) disable iff (!aresetn) busy_reg |-> !req_i.start)
        else $error("multiplier restarted while busy");

    // The done pulse follows the final step and lasts one cycle.
    assert property (@(posedge aclk) disable iff (!aresetn) done_reg |=> !done_reg)
        else $error("multiplier done held for more than one cycle");

    // The step count stays within the multiplier width.
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg < tsm_pkg::CNT_W'(tsm_pkg::MPLIER_W))
        else $error("multiplier step count out of range");

endmodule

// ----- rtl/core/tsm_mixer.sv -----
module tsm_mixer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tsm_pkg::cfg_t                       cfg_i,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [tsm_pkg::MODE_W-1:0]          s_mode,
    input  logic signed [tsm_pkg::SPEED_W-1:0]  s_speed,
    input  logic signed [tsm_pkg::SPEED_W-1:0]  s_turn_ratio,
    input  logic signed [tsm_pkg::SPEED_W-1:0]  s_left_value,
    input  logic signed [tsm_pkg::SPEED_W-1:0]  s_right_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [tsm_pkg::SPEED_W-1:0]  m_left_command,
    output logic signed [tsm_pkg::SPEED_W-1:0]  m_right_command
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ARC    = 6'b000010,
        S_CLAMP  = 6'b000100,
        S_CORR_L = 6'b001000,
        S_CORR_R = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    localparam int TW = tsm_pkg::MCAND_W;
    localparam int CW = tsm_pkg::CMD_W;

    state_t state_reg;
    state_t state_next;

    logic signed [TW-1:0]                  lt_reg;
    logic signed [TW-1:0]                  rt_reg;
    logic                                  arc_right_reg;
    logic signed [tsm_pkg::SPEED_W-1:0]    lmeas_reg;
    logic signed [tsm_pkg::SPEED_W-1:0]    rmeas_reg;
    logic signed [tsm_pkg::SPEED_W-1:0]    lcmd_reg;
    logic signed [tsm_pkg::SPEED_W-1:0]    rcmd_reg;
    logic                                  m_valid_reg;
    logic signed [tsm_pkg::SPEED_W-1:0]    m_left_reg;
    logic signed [tsm_pkg::SPEED_W-1:0]    m_right_reg;

    tsm_pkg::mul_req_t mul_req;
    tsm_pkg::mul_rsp_t mul_rsp;

    logic                                  accept;
    logic                                  out_free;
    logic signed [TW-1:0]                  speed_x;
    logic signed [10:0]                    ratio_c;
    logic signed [10:0]                    factor;
    logic signed [10:0]                    factor_mag;
    logic signed [tsm_pkg::SPEED_W-1:0]    lt_clamp;
    logic signed [tsm_pkg::SPEED_W-1:0]    rt_clamp;
    logic signed [TW-1:0]                  err_l;
    logic signed [TW-1:0]                  err_r;
    logic signed [tsm_pkg::RND_W-1:0]      rounded;
    logic signed [tsm_pkg::SPEED_W-1:0]    arc_track;
    logic signed [CW-1:0]                  lt_w;
    logic signed [CW-1:0]                  rt_w;
    logic signed [CW-1:0]                  corr_w;
    logic signed [tsm_pkg::SPEED_W-1:0]    lcmd_corr;
    logic signed [tsm_pkg::SPEED_W-1:0]    rcmd_corr;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Arc factor 1.0 minus or plus the clamped ratio, split into sign and magnitude.
    always_comb begin
        speed_x = {s_speed[tsm_pkg::SPEED_W-1], s_speed};
        if (s_turn_ratio > 16'(tsm_pkg::RATIO_LIMIT)) begin
            ratio_c = tsm_pkg::RATIO_LIMIT;
        end else if (s_turn_ratio < -16'(tsm_pkg::RATIO_LIMIT)) begin
            ratio_c = -tsm_pkg::RATIO_LIMIT;
        end else begin
            ratio_c = s_turn_ratio[10:0];
        end
        factor     = ratio_c[10] ? (tsm_pkg::Q_ONE + ratio_c) : (tsm_pkg::Q_ONE - ratio_c);
        factor_mag = factor[10] ? -factor : factor;
    end

    // Clamped targets and speed errors.
    always_comb begin
        lt_clamp = tsm_pkg::clamp_speed(CW'(lt_reg), cfg_i.max_speed);
        rt_clamp = tsm_pkg::clamp_speed(CW'(rt_reg), cfg_i.max_speed);
        err_l    = TW'(lt_clamp) - TW'(lmeas_reg);
        err_r    = rt_reg - TW'(rmeas_reg);
    end

    // Rounded product and the corrected commands built from it.
    always_comb begin
        rounded   = tsm_pkg::round_q8(mul_rsp.product);
        arc_track = tsm_pkg::sat16(rounded);
        lt_w      = CW'(lt_reg);
        rt_w      = CW'(rt_reg);
        corr_w    = CW'(rounded);
        lcmd_corr = tsm_pkg::clamp_speed(cfg_i.flip_left ? (-lt_w - corr_w)
                                                         : (lt_w + corr_w),
                                         cfg_i.max_speed);
        rcmd_corr = tsm_pkg::clamp_speed(cfg_i.flip_right ? (-rt_w - corr_w)
                                                          : (rt_w + corr_w),
                                         cfg_i.max_speed);
    end

    // Multiplier requests: arc scaling, then one correction per track when correction is enabled.
    always_comb begin
        mul_req.start  = 1'b0;
        mul_req.mcand  = err_r;
        mul_req.mplier = cfg_i.correction_gain;
        priority if (accept && s_mode == tsm_pkg::MODE_ARC) begin
            mul_req.start  = 1'b1;
            mul_req.mcand  = factor[10] ? -speed_x : speed_x;
            mul_req.mplier = {3'b000, factor_mag[8:0]};
        end else if (state_reg == S_CLAMP && cfg_i.correction_enable) begin
            mul_req.start = 1'b1;
            mul_req.mcand = err_l;
        end else if (state_reg == S_CORR_L && mul_rsp.done) begin
            mul_req.start = 1'b1;
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (s_mode)
                        tsm_pkg::MODE_STRAIGHT, tsm_pkg::MODE_ROTATE,
                        tsm_pkg::MODE_STOP, tsm_pkg::MODE_DIRECT: state_next = S_CLAMP;
                        tsm_pkg::MODE_ARC: state_next = S_ARC;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_ARC:    if (mul_rsp.done) state_next = S_CLAMP;
            S_CLAMP:  state_next = cfg_i.correction_enable ? S_CORR_L : S_OUT;
            S_CORR_L: if (mul_rsp.done) state_next = S_CORR_R;
            S_CORR_R: if (mul_rsp.done) state_next = S_OUT;
            S_OUT:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            lmeas_reg   <= '0;
            rmeas_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept && s_mode == tsm_pkg::MODE_TELEM) begin
                lmeas_reg <= s_left_value;
                rmeas_reg <= s_right_value;
            end
        end
    end

    // Targets and commands.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                arc_right_reg <= !ratio_c[10];
                unique case (s_mode)
                    tsm_pkg::MODE_STRAIGHT, tsm_pkg::MODE_ARC: begin
                        lt_reg <= speed_x;
                        rt_reg <= speed_x;
                    end
                    tsm_pkg::MODE_ROTATE: begin
                        lt_reg <= speed_x;
                        rt_reg <= -speed_x;
                    end
                    tsm_pkg::MODE_DIRECT: begin
                        lt_reg <= TW'(s_left_value);
                        rt_reg <= TW'(s_right_value);
                    end
                    default: begin
                        lt_reg <= '0;
                        rt_reg <= '0;
                    end
                endcase
            end
            S_ARC: begin
                if (mul_rsp.done) begin
                    if (arc_right_reg) begin
                        rt_reg <= TW'(arc_track);
                    end else begin
                        lt_reg <= TW'(arc_track);
                    end
                end
            end
            S_CLAMP: begin
                lt_reg   <= TW'(lt_clamp);
                rt_reg   <= TW'(rt_clamp);
                lcmd_reg <= cfg_i.flip_left ? -lt_clamp : lt_clamp;
                rcmd_reg <= cfg_i.flip_right ? -rt_clamp : rt_clamp;
            end
            S_CORR_L: if (mul_rsp.done) lcmd_reg <= lcmd_corr;
            S_CORR_R: if (mul_rsp.done) rcmd_reg <= rcmd_corr;
            S_OUT: begin
                if (out_free) begin
                    m_left_reg  <= lcmd_reg;
                    m_right_reg <= rcmd_reg;
                end
            end
            default: ;
        endcase
    end

    tsm_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_i   (mul_req),
        .rsp_o   (mul_rsp)
    );

    assign m_valid         = m_valid_reg;
    assign m_left_command  = m_left_reg;
    assign m_right_command = m_right_reg;

    // Without correction the multiplier is only started for an arc command.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mul_req.start && !cfg_i.correction_enable) |-> state_reg == S_IDLE)
        else $error("correction product started while correction is off");

    // A product only arrives while the sequencer waits for one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_rsp.done |-> (state_reg == S_ARC || state_reg == S_CORR_L ||
                          state_reg == S_CORR_R))
        else $error("product arrived in an unexpected state");

    // A finished result waits while the output beat is still pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && m_valid_reg && !m_ready) |=> state_reg == S_OUT)
        else $error("result overwrote a pending output beat");

    // Unused modes leave the measured speeds and the sequencer alone.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_mode > tsm_pkg::MODE_TELEM) |=>
            (state_reg == S_IDLE && $stable(lmeas_reg) && $stable(rmeas_reg)))
        else $error("unused mode changed state");

endmodule

// ----- rtl/core/track_speed_mixer_top.sv -----
// Track speed mixer: turns one motion command beat (straight, rotate, arc, stop or
// direct track speeds) into one beat of left and right Q7.8 track setpoints, limited
// to the configured maximum speed, with optional proportional correction against the
// last measured speeds; a telemetry beat only stores the measured speeds. Commands are
// taken one at a time and all products come from one bit-serial 17 by 12 bit
// shift-and-add multiplier. A command passes from acceptance through a clamp step
// and an output step to its result beat, with the arc product before the clamp step
// and one correction product per track after it when correction is on.
// The next command is accepted while a finished result still waits on the output.
module track_speed_mixer_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tsm_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [tsm_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [tsm_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [tsm_pkg::MODE_W-1:0]          s_mode,
    input  logic signed [tsm_pkg::SPEED_W-1:0]  s_speed,
    input  logic signed [tsm_pkg::SPEED_W-1:0]  s_turn_ratio,
    input  logic signed [tsm_pkg::SPEED_W-1:0]  s_left_value,
    input  logic signed [tsm_pkg::SPEED_W-1:0]  s_right_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [tsm_pkg::SPEED_W-1:0]  m_left_command,
    output logic signed [tsm_pkg::SPEED_W-1:0]  m_right_command
);

    tsm_pkg::cfg_t cfg;

    // Configuration registers.
    tsm_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg_o   (cfg)
    );

    // Mixing datapath and sequencer.
    tsm_mixer u_mixer (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_i           (cfg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_speed         (s_speed),
        .s_turn_ratio    (s_turn_ratio),
        .s_left_value    (s_left_value),
        .s_right_value   (s_right_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_left_command  (m_left_command),
        .m_right_command (m_right_command)
    );

endmodule
